// ===== hw/rtl/scad_pkg.sv =====
// ----------------------------------------------------------------------------
// scad_pkg: shared types, codes and keymap for the scancode decoder
// Holds the action codes, the held-key state, the result struct and the
// set-1 US keymap lookup.
// ----------------------------------------------------------------------------
package scad_pkg;

	// Number of screens stepped with Alt+arrow (2..16)
	localparam int SCREEN_COUNT = 4;
	localparam logic [3:0] SCREEN_LAST = 4'(SCREEN_COUNT - 1);

	// Set-1 scancodes with a special meaning
	localparam logic [7:0] SC_CTRL  = 8'h1D;
	localparam logic [7:0] SC_ALT   = 8'h38;
	localparam logic [7:0] SC_UP    = 8'h48;
	localparam logic [7:0] SC_DOWN  = 8'h50;
	localparam logic [7:0] SC_LEFT  = 8'h4B;
	localparam logic [7:0] SC_RIGHT = 8'h4D;
	localparam logic [7:0] SC_DEL   = 8'h53;
	localparam logic [7:0] SC_BREAK = 8'h80;

	// Keymap characters with a special meaning
	localparam logic [6:0] CH_NONE  = 7'h00;
	localparam logic [6:0] CH_BKSP  = 7'h08;
	localparam logic [6:0] CH_ENTER = 7'h0A;
	localparam logic [6:0] CH_CLEAR = 7'h6C; // 'l'
	localparam logic [6:0] CH_INTR  = 7'h63; // 'c'
	localparam logic [6:0] CH_PANIC = 7'h64; // 'd'

	typedef enum logic [3:0] {
		ACT_NONE   = 4'd0,
		ACT_SCREEN = 4'd1,
		ACT_CLEAR  = 4'd2,
		ACT_INTR   = 4'd3,
		ACT_PANIC  = 4'd4,
		ACT_CTRL   = 4'd5,
		ACT_UP     = 4'd6,
		ACT_DOWN   = 4'd7,
		ACT_LEFT   = 4'd8,
		ACT_RIGHT  = 4'd9,
		ACT_DELETE = 4'd10,
		ACT_BKSP   = 4'd11,
		ACT_ENTER  = 4'd12,
		ACT_PRINT  = 4'd13
	} action_t;

	// Modifier flags and screen index kept between items
	typedef struct packed {
		logic       ctrl_held;
		logic       alt_held;
		logic [3:0] screen;
	} key_state_t;

	// One decoded result item
	typedef struct packed {
		action_t    action;
		logic [6:0] char_code;
		logic [3:0] screen_index;
		logic       drop_char;
	} key_result_t;

	// US keymap, 128 entries; zero marks an unmapped key
	function automatic logic [6:0] us_keymap(input logic [6:0] idx);
		logic [6:0] ch;
		case (idx)
			7'h01: ch = 7'h1B; // escape
			7'h02: ch = 7'h31;
			7'h03: ch = 7'h32;
			7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;
			7'h06: ch = 7'h35;
			7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;
			7'h09: ch = 7'h38;
			7'h0A: ch = 7'h39;
			7'h0B: ch = 7'h30;
			7'h0C: ch = 7'h2D;
			7'h0D: ch = 7'h3D;
			7'h0E: ch = 7'h08; // backspace
			7'h0F: ch = 7'h09; // tab
			7'h10: ch = 7'h71;
			7'h11: ch = 7'h77;
			7'h12: ch = 7'h65;
			7'h13: ch = 7'h72;
			7'h14: ch = 7'h74;
			7'h15: ch = 7'h79;
			7'h16: ch = 7'h75;
			7'h17: ch = 7'h69;
			7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;
			7'h1A: ch = 7'h5B;
			7'h1B: ch = 7'h5D;
			7'h1C: ch = 7'h0A; // enter
			7'h1E: ch = 7'h61;
			7'h1F: ch = 7'h73;
			7'h20: ch = 7'h64;
			7'h21: ch = 7'h66;
			7'h22: ch = 7'h67;
			7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A;
			7'h25: ch = 7'h6B;
			7'h26: ch = 7'h6C;
			7'h27: ch = 7'h3B;
			7'h28: ch = 7'h27;
			7'h29: ch = 7'h60;
			7'h2B: ch = 7'h5C;
			7'h2C: ch = 7'h7A;
			7'h2D: ch = 7'h78;
			7'h2E: ch = 7'h63;
			7'h2F: ch = 7'h76;
			7'h30: ch = 7'h62;
			7'h31: ch = 7'h6E;
			7'h32: ch = 7'h6D;
			7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E;
			7'h35: ch = 7'h2F;
			7'h37: ch = 7'h2A;
			7'h39: ch = 7'h20;
			7'h4A: ch = 7'h2D;
			7'h4E: ch = 7'h2B;
			default: ch = CH_NONE;
		endcase
		return ch;
	endfunction

endpackage

// ===== hw/rtl/scad_decode.sv =====
// ----------------------------------------------------------------------------
// scad_decode: combinational scancode decode
// Maps one scancode and the held-key state to a result item and the state
// that follows it.
// ----------------------------------------------------------------------------
module scad_decode
	import scad_pkg::*;
(
	input  logic [7:0]  code,
	input  key_state_t  state_cur,
	output key_state_t  state_nxt,
	output key_result_t result
);

	logic [6:0] map_ch;
	action_t    act;
	logic [6:0] ch;
	logic       drop;

	assign map_ch = us_keymap(code[6:0]);

	// Pick the action and update modifiers and screen
	always_comb begin
		state_nxt = state_cur;
		act       = ACT_NONE;
		ch        = CH_NONE;
		drop      = 1'b0;
		if (code == SC_CTRL) begin
			state_nxt.ctrl_held = 1'b1;
		end else if (code == (SC_CTRL | SC_BREAK)) begin
			state_nxt.ctrl_held = 1'b0;
		end else if (code == SC_ALT) begin
			state_nxt.alt_held = 1'b1;
		end else if (code == (SC_ALT | SC_BREAK)) begin
			state_nxt.alt_held = 1'b0;
		end else if (code[7]) begin
			// other release: nothing to do
		end else if (state_cur.alt_held) begin
			if (code == SC_LEFT && state_cur.screen != 4'd0) begin
				state_nxt.screen = state_cur.screen - 4'd1;
				act              = ACT_SCREEN;
			end else if (code == SC_RIGHT && state_cur.screen < SCREEN_LAST) begin
				state_nxt.screen = state_cur.screen + 4'd1;
				act              = ACT_SCREEN;
			end
		end else if (state_cur.ctrl_held) begin
			drop = 1'b1;
			if (map_ch == CH_CLEAR) begin
				act = ACT_CLEAR;
			end else if (map_ch == CH_INTR) begin
				act = ACT_INTR;
			end else if (map_ch == CH_PANIC) begin
				act = ACT_PANIC;
			end else begin
				act = ACT_CTRL;
			end
		end else if (code == SC_UP) begin
			act = ACT_UP;
		end else if (code == SC_DOWN) begin
			act = ACT_DOWN;
		end else if (code == SC_LEFT) begin
			act = ACT_LEFT;
		end else if (code == SC_RIGHT) begin
			act = ACT_RIGHT;
		end else if (code == SC_DEL) begin
			act = ACT_DELETE;
		end else if (map_ch == CH_BKSP) begin
			act  = ACT_BKSP;
			drop = 1'b1;
		end else if (map_ch == CH_ENTER) begin
			act = ACT_ENTER;
		end else if (map_ch != CH_NONE) begin
			act = ACT_PRINT;
			ch  = map_ch;
		end
	end

	assign result.action       = act;
	assign result.char_code    = ch;
	assign result.screen_index = state_nxt.screen;
	assign result.drop_char    = drop;

endmodule

// ===== hw/rtl/scancode_key_action_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// scancode_key_action_decoder_unit: set-1 scancode to key action decoder
// Turns each received scancode into one action item with modifier tracking
// and a kept screen index.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel key_valid / key_stall carries one scancode per item.
//   Output channel act_valid / act_stall carries one result per item:
//   action, char_code, screen_index, drop_char.
//   An item is taken at a clock edge with valid high and stall low.
//   The item sits in the input register while the decode between the two
//   registers loads the result register. Throughput: one item per cycle
//   while act_stall is low, set by the single decode pass between the two
//   registers.
//   When the receiver stalls, the held result stays in place; the input
//   register still fills, and key_stall rises only once both registers
//   hold an item.
//   Reset (arst_n low) empties both registers and clears the Ctrl and Alt
//   flags and the screen index to zero.
// ----------------------------------------------------------------------------
module scancode_key_action_decoder_unit
	import scad_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       key_valid,
	output logic       key_stall,
	input  logic [7:0] scancode,
	output logic       act_valid,
	input  logic       act_stall,
	output logic [3:0] action,
	output logic [6:0] char_code,
	output logic [3:0] screen_index,
	output logic       drop_char
);

	logic        valid_s1;
	logic [7:0]  scancode_s1;
	logic        out_valid_q;
	key_result_t res_q;
	key_state_t  state_q;
	key_state_t  state_nxt;
	key_result_t res_nxt;
	logic        out_hold;
	logic        advance;
	logic        accept;

	// Handshake: result register holds while stalled
	assign out_hold  = out_valid_q && act_stall;
	assign advance   = valid_s1 && !out_hold;
	assign key_stall = valid_s1 && out_hold;
	assign accept    = key_valid && !key_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scancode_s1 <= scancode;
		end
	end

	// Decode the held item
	scad_decode u_decode (
		.code      (scancode_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (res_nxt)
	);

	// Advance modifier state with each decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!act_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign act_valid    = out_valid_q;
	assign action       = res_q.action;
	assign char_code    = res_q.char_code;
	assign screen_index = res_q.screen_index;
	assign drop_char    = res_q.drop_char;

	// A printed item carries a mapped character, any other carries zero
	assert property (@(posedge clk) disable iff (!arst_n)
		act_valid |-> ((res_q.action == ACT_PRINT) == (res_q.char_code != CH_NONE)))
		else $error("char_code does not match action");

	// Drop only with Ctrl actions or backspace
	assert property (@(posedge clk) disable iff (!arst_n)
		(act_valid && drop_char) |->
		(res_q.action == ACT_CLEAR || res_q.action == ACT_INTR ||
		 res_q.action == ACT_PANIC || res_q.action == ACT_CTRL ||
		 res_q.action == ACT_BKSP))
		else $error("drop_char with wrong action");

	// Kept screen index stays within range
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.screen <= SCREEN_LAST)
		else $error("screen index out of range");

	// State changes only when an item is decoded
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without an item");

endmodule
